// ----- rtl/core/tam_pkg.sv -----
// Shared types, widths and codes of the thruster actuator model.
`timescale 1ns / 1ps
`default_nettype none

package tam_pkg;

  localparam int IDX_W  = 3;
  localparam int CMD_W  = 16;
  localparam int LVL_W  = 24;
  localparam int LIM_W  = 15;
  localparam int LAG_W  = 16;
  localparam int DLY_W  = 5;
  localparam int CRV_W  = 63;
  localparam int COEF_W = 21;
  localparam int FRC_W  = 32;
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_INPUT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAG_COEFFICIENT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_STEPS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_POSITIVE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_NEGATIVE = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RING,
    ST_DLY,
    ST_LAG,
    ST_SQ,
    ST_FA,
    ST_FB,
    ST_FC,
    ST_FD,
    ST_FE,
    ST_OUT
  } tam_state_e;

  typedef struct packed {
    logic             st_rd;
    logic             ring_go;
    logic             st_wr;
    logic [IDX_W-1:0] idx;
    logic [CMD_W-1:0] cmd;
    logic [LVL_W-1:0] level;
    logic [DLY_W-1:0] delay_steps;
  } store_req_t;

  typedef struct packed {
    logic             busy;
    logic [LVL_W-1:0] level_old;
    logic [CMD_W-1:0] u;
  } store_rsp_t;

  typedef struct packed {
    logic [MUL_W-1:0] opa;
    logic [MUL_W-1:0] opb;
  } mac_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/tam_mac.sv -----
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module tam_mac (
  input  wire logic                           clk_i,
  input  wire tam_pkg::mac_req_t              req_i,
  output logic signed [tam_pkg::PROD_W-1:0]   prod_o
);

  logic signed [tam_pkg::PROD_W-1:0] prod_q;
  logic signed [tam_pkg::PROD_W-1:0] prod_d;

  always_comb begin
    prod_d = $signed(req_i.opa) * $signed(req_i.opb);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- rtl/core/tam_store.sv -----
// Delay ring memory and per-thruster state memory with clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module tam_store #(
  parameter int THRUSTERS   = 8,
  parameter int DELAY_DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tam_pkg::store_req_t req_i,
  output tam_pkg::store_rsp_t      rsp_o
);

  localparam int NENT = THRUSTERS * DELAY_DEPTH;
  localparam int TW   = (THRUSTERS > 1) ? $clog2(THRUSTERS) : 1;
  localparam int PW   = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int AW   = (NENT > 1) ? $clog2(NENT) : 1;
  localparam int CLW  = $clog2(NENT + 1);
  localparam int RW   = (($clog2(DELAY_DEPTH + 1) > tam_pkg::DLY_W) ?
                         $clog2(DELAY_DEPTH + 1) : tam_pkg::DLY_W) + 1;
  localparam int SW   = PW + tam_pkg::LVL_W;

  localparam logic [AW-1:0] DEPTH_A = AW'(DELAY_DEPTH);
  localparam logic [RW-1:0] DEPTH_R = RW'(DELAY_DEPTH);

  logic [tam_pkg::CMD_W-1:0] dmem [NENT];
  logic [SW-1:0]             smem [THRUSTERS];

  logic [CLW-1:0]            clr_cnt_q;
  logic                      busy;
  logic [SW-1:0]             st_q;
  logic [tam_pkg::CMD_W-1:0] drd_q;
  logic [tam_pkg::CMD_W-1:0] fcmd_q;
  logic                      fwd_q;
  logic [PW-1:0]             pos_next_q;
  logic [PW-1:0]             pos_next_d;

  logic [TW-1:0]             sidx;
  logic [PW-1:0]             pos;
  logic [RW-1:0]             d_eff;
  logic [RW-1:0]             dm1;
  logic [RW-1:0]             rsum;
  logic [PW-1:0]             rpos;
  logic [AW-1:0]             base;
  logic [AW-1:0]             waddr;
  logic [AW-1:0]             raddr;

  assign busy = (clr_cnt_q != CLW'(NENT));
  assign sidx = TW'(req_i.idx);
  assign pos  = st_q[SW-1:tam_pkg::LVL_W];

  always_comb begin
    d_eff = RW'(req_i.delay_steps);
    if (d_eff == '0) begin
      d_eff = RW'(1);
    end else if (d_eff > DEPTH_R) begin
      d_eff = DEPTH_R;
    end
    dm1  = d_eff - RW'(1);
    rsum = RW'(pos) + DEPTH_R - dm1;
    if (rsum >= DEPTH_R) begin
      rsum = rsum - DEPTH_R;
    end
    rpos  = rsum[PW-1:0];
    base  = AW'(sidx) * DEPTH_A;
    waddr = base + AW'(pos);
    raddr = base + AW'(rpos);
    if (pos == PW'(DELAY_DEPTH - 1)) begin
      pos_next_d = '0;
    end else begin
      pos_next_d = pos + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (busy) begin
      clr_cnt_q <= clr_cnt_q + CLW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy) begin
      dmem[clr_cnt_q[AW-1:0]] <= '0;
    end else if (req_i.ring_go) begin
      dmem[waddr] <= req_i.cmd;
    end
    if (req_i.ring_go) begin
      drd_q      <= dmem[raddr];
      fcmd_q     <= req_i.cmd;
      fwd_q      <= (dm1 == '0);
      pos_next_q <= pos_next_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy) begin
      if (clr_cnt_q < CLW'(THRUSTERS)) begin
        smem[clr_cnt_q[TW-1:0]] <= '0;
      end
    end else if (req_i.st_wr) begin
      smem[sidx] <= {pos_next_q, req_i.level};
    end
    if (req_i.st_rd) begin
      st_q <= smem[sidx];
    end
  end

  always_comb begin
    rsp_o.busy      = busy;
    rsp_o.level_old = st_q[tam_pkg::LVL_W-1:0];
    rsp_o.u         = fwd_q ? fcmd_q : drd_q;
  end

endmodule

`default_nettype wire

// ----- rtl/core/thruster_actuator_model_unit.sv -----
// Top level of the thruster actuator model: control sequencer, lag and force datapath.
//
// Input channel in_valid_i / in_stall_o carries thruster_index_i and command_i;
// output channel out_valid_o / out_stall_i carries thruster_out_index_o,
// actuator_level_o and force_res_o. A transfer happens at a rising edge with
// valid high and stall low. Configuration is a plain write port
// (cfg_we_i, cfg_idx_i, cfg_wdata_i), and must be written only while the block is
// idle; the block itself does not enforce this. One item is processed at a time.
// For a valid thruster an item takes one state memory read, one delay ring access,
// then six products through the single shared 25x25 multiplier and a final add and
// saturate. An out-of-range thruster goes straight to the output state with a zero
// level and force. The result waits in an output register, so a stalled receiver
// holds the payload steady while the next item is already accepted; a second result
// waits until the first is transferred.
// After reset the block clears the delay ring and the per-thruster state in a
// pass over all THRUSTERS*DELAY_DEPTH ring entries, holding in_stall_o high;
// configuration writes are taken during that pass.
`timescale 1ns / 1ps
`default_nettype none

module thruster_actuator_model_unit #(
  parameter int THRUSTERS   = 8,
  parameter int DELAY_DEPTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [tam_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [tam_pkg::CRV_W-1:0]           cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [tam_pkg::IDX_W-1:0]           thruster_index_i,
  input  wire logic signed [tam_pkg::CMD_W-1:0]    command_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [tam_pkg::IDX_W-1:0]                thruster_out_index_o,
  output logic signed [tam_pkg::LVL_W-1:0]         actuator_level_o,
  output logic signed [tam_pkg::FRC_W-1:0]         force_res_o
);

  localparam int SUM_W = 42;
  localparam int LV_W  = SUM_W - 16;
  localparam int TOP_W = 45;
  localparam int LOW_W = 64;
  localparam int F_W   = 46;

  tam_pkg::tam_state_e state_q, state_d;

  logic [tam_pkg::LIM_W-1:0] max_q;
  logic [tam_pkg::LIM_W-1:0] dz_q;
  logic [tam_pkg::LAG_W-1:0] lag_q;
  logic [tam_pkg::DLY_W-1:0] dly_q;
  logic [tam_pkg::CRV_W-1:0] cpos_q;
  logic [tam_pkg::CRV_W-1:0] cneg_q;

  logic [tam_pkg::IDX_W-1:0]         idx_q;
  logic signed [tam_pkg::CMD_W-1:0]  cmd_q;
  logic signed [SUM_W-1:0]           sum_q;
  logic signed [tam_pkg::LVL_W-1:0]  lvl_q;
  logic [tam_pkg::LVL_W-1:0]         mag_q;
  logic [23:0]                       lo_q;
  logic signed [tam_pkg::COEF_W-1:0] a_q, b_q, c_q;
  logic signed [TOP_W-1:0]           top_q;
  logic signed [LOW_W-1:0]           low_q;
  logic signed [tam_pkg::FRC_W-1:0]  f_q;

  logic                              out_valid_q;
  logic [tam_pkg::IDX_W-1:0]         out_idx_q;
  logic signed [tam_pkg::LVL_W-1:0]  out_lvl_q;
  logic signed [tam_pkg::FRC_W-1:0]  out_f_q;

  tam_pkg::store_req_t               sreq;
  tam_pkg::store_rsp_t               srsp;
  tam_pkg::mac_req_t                 mreq;
  logic signed [tam_pkg::PROD_W-1:0] prod;

  logic                              in_acc;
  logic                              oor;
  logic                              out_load;
  logic signed [16:0]                cl;
  logic signed [16:0]                lim17;
  logic [16:0]                       cmag;
  logic [tam_pkg::CMD_W-1:0]         cmd_clamped;
  logic signed [SUM_W-1:0]           lag_sum;
  logic signed [LV_W-1:0]            lag_lvl;
  logic signed [LV_W-1:0]            lim_lvl;
  logic signed [LV_W-1:0]            lvl_next;
  logic [tam_pkg::LVL_W-1:0]         lvl_mag;
  logic signed [F_W-1:0]             f_full;
  logic [tam_pkg::CRV_W-1:0]         curve;

  tam_store #(
    .THRUSTERS   (THRUSTERS),
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sreq),
    .rsp_o  (srsp)
  );

  tam_mac u_mac (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .prod_o (prod)
  );

  assign in_acc   = in_valid_i && !in_stall_o;
  assign oor      = ({2'b00, thruster_index_i} >= 5'(THRUSTERS));
  assign out_load = (state_q == tam_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    lim17 = $signed({2'b00, max_q});
    cl    = $signed({cmd_q[tam_pkg::CMD_W-1], cmd_q});
    if (cl > lim17) begin
      cl = lim17;
    end else if (cl < -lim17) begin
      cl = -lim17;
    end
    cmag = cl[16] ? 17'(-cl) : 17'(cl);
    if (cmag < {2'b00, dz_q}) begin
      cl = '0;
    end
    cmd_clamped = cl[tam_pkg::CMD_W-1:0];
  end

  always_comb begin
    lag_sum = sum_q + $signed(prod[SUM_W-1:0]) + 42'sd32768;
    lag_lvl = lag_sum[SUM_W-1:16];
    lim_lvl = $signed({3'b000, max_q, 8'h00});
    if (lag_lvl > lim_lvl) begin
      lvl_next = lim_lvl;
    end else if (lag_lvl < -lim_lvl) begin
      lvl_next = -lim_lvl;
    end else begin
      lvl_next = lag_lvl;
    end
    lvl_mag = lvl_q[tam_pkg::LVL_W-1] ? tam_pkg::LVL_W'(-lvl_q) : lvl_q;
    curve   = lvl_q[tam_pkg::LVL_W-1] ? cneg_q : cpos_q;
    f_full  = {top_q[TOP_W-1], top_q} + {{6{low_q[LOW_W-1]}}, low_q[LOW_W-1:24]};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tam_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = oor ? tam_pkg::ST_OUT : tam_pkg::ST_RING;
        end
      end
      tam_pkg::ST_RING: state_d = tam_pkg::ST_DLY;
      tam_pkg::ST_DLY:  state_d = tam_pkg::ST_LAG;
      tam_pkg::ST_LAG:  state_d = tam_pkg::ST_SQ;
      tam_pkg::ST_SQ:   state_d = tam_pkg::ST_FA;
      tam_pkg::ST_FA:   state_d = tam_pkg::ST_FB;
      tam_pkg::ST_FB:   state_d = tam_pkg::ST_FC;
      tam_pkg::ST_FC:   state_d = tam_pkg::ST_FD;
      tam_pkg::ST_FD:   state_d = tam_pkg::ST_FE;
      tam_pkg::ST_FE:   state_d = tam_pkg::ST_OUT;
      tam_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = tam_pkg::ST_IDLE;
        end
      end
      default: state_d = tam_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o        = (state_q != tam_pkg::ST_IDLE) || srsp.busy;
    sreq              = '0;
    sreq.idx          = (state_q == tam_pkg::ST_IDLE) ? thruster_index_i : idx_q;
    sreq.cmd          = cmd_clamped;
    sreq.level        = lvl_q;
    sreq.delay_steps  = dly_q;
    mreq              = '0;
    case (state_q)
      tam_pkg::ST_IDLE: begin
        sreq.st_rd = in_valid_i && !srsp.busy && !oor;
      end
      tam_pkg::ST_RING: begin
        sreq.ring_go = 1'b1;
        mreq.opa     = {9'd0, lag_q};
        mreq.opb     = {srsp.level_old[tam_pkg::LVL_W-1], srsp.level_old};
      end
      tam_pkg::ST_DLY: begin
        mreq.opa = {8'd0, 17'h10000 - {1'b0, lag_q}};
        mreq.opb = {srsp.u[tam_pkg::CMD_W-1], srsp.u, 8'h00};
      end
      tam_pkg::ST_SQ: begin
        sreq.st_wr = 1'b1;
        mreq.opa   = {1'b0, lvl_mag};
        mreq.opb   = {1'b0, lvl_mag};
      end
      tam_pkg::ST_FA: begin
        mreq.opa = {{4{a_q[tam_pkg::COEF_W-1]}}, a_q};
        mreq.opb = {3'd0, prod[45:24]};
      end
      tam_pkg::ST_FB: begin
        mreq.opa = {{4{a_q[tam_pkg::COEF_W-1]}}, a_q};
        mreq.opb = {1'b0, lo_q};
      end
      tam_pkg::ST_FC: begin
        mreq.opa = {{4{b_q[tam_pkg::COEF_W-1]}}, b_q};
        mreq.opb = {1'b0, mag_q};
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tam_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      max_q       <= 15'h7FFF;
      dz_q        <= '0;
      lag_q       <= '0;
      dly_q       <= 5'd1;
      cpos_q      <= '0;
      cneg_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tam_pkg::REG_MAX_INPUT:       max_q  <= cfg_wdata_i[tam_pkg::LIM_W-1:0];
          tam_pkg::REG_DEAD_ZONE:       dz_q   <= cfg_wdata_i[tam_pkg::LIM_W-1:0];
          tam_pkg::REG_LAG_COEFFICIENT: lag_q  <= cfg_wdata_i[tam_pkg::LAG_W-1:0];
          tam_pkg::REG_DELAY_STEPS:     dly_q  <= cfg_wdata_i[tam_pkg::DLY_W-1:0];
          tam_pkg::REG_CURVE_POSITIVE:  cpos_q <= cfg_wdata_i;
          tam_pkg::REG_CURVE_NEGATIVE:  cneg_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      tam_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx_q <= thruster_index_i;
          cmd_q <= command_i;
          if (oor) begin
            lvl_q <= '0;
            f_q   <= '0;
          end
        end
      end
      tam_pkg::ST_DLY: begin
        sum_q <= $signed(prod[SUM_W-1:0]);
      end
      tam_pkg::ST_LAG: begin
        lvl_q <= lvl_next[tam_pkg::LVL_W-1:0];
      end
      tam_pkg::ST_SQ: begin
        mag_q <= lvl_mag;
        a_q   <= $signed(curve[20:0]);
        b_q   <= $signed(curve[41:21]);
        c_q   <= $signed(curve[62:42]);
      end
      tam_pkg::ST_FA: begin
        lo_q <= prod[23:0];
      end
      tam_pkg::ST_FB: begin
        top_q <= $signed(prod[TOP_W-1:0]) + {{24{c_q[tam_pkg::COEF_W-1]}}, c_q};
      end
      tam_pkg::ST_FC: begin
        low_q <= {{14{prod[tam_pkg::PROD_W-1]}}, prod} + 64'sd8388608;
      end
      tam_pkg::ST_FD: begin
        low_q <= low_q + ({{14{prod[tam_pkg::PROD_W-1]}}, prod} <<< 16);
      end
      tam_pkg::ST_FE: begin
        if (f_full > 46'sd2147483647) begin
          f_q <= 32'sh7FFFFFFF;
        end else if (f_full < -46'sd2147483648) begin
          f_q <= 32'sh80000000;
        end else begin
          f_q <= f_full[tam_pkg::FRC_W-1:0];
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_idx_q <= idx_q;
      out_lvl_q <= lvl_q;
      out_f_q   <= f_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign thruster_out_index_o = out_idx_q;
  assign actuator_level_o     = out_lvl_q;
  assign force_res_o          = out_f_q;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input transfer while an item is in flight");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    srsp.busy |-> in_stall_o)
    else $error("input accepted during clearing pass");

  a_result_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == tam_pkg::ST_OUT))
    else $error("result raised outside the output state");

  a_level_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tam_pkg::ST_SQ) |->
      ($signed({lvl_q[tam_pkg::LVL_W-1], lvl_q}) <= $signed({2'b00, max_q, 8'h00}) &&
       $signed({lvl_q[tam_pkg::LVL_W-1], lvl_q}) >= -$signed({2'b00, max_q, 8'h00})))
    else $error("lagged level outside the saturation limit");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the thruster actuator model: lag, transport delay and force curve.
`timescale 1ns / 1ps

module tb_top;
  import tam_pkg::*;

  localparam int THR_COUNT = 8;
  localparam int RING_DEPTH = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 30;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

  typedef enum logic {ROW_CMD, ROW_CFG} step_kind_e;

  typedef struct packed {
    step_kind_e              kind;
    logic [CFG_IDX_W-1:0]    sel;
    logic [CRV_W-1:0]        data;
    logic                    typed;
    logic signed [LVL_W-1:0] lvl;
    logic signed [FRC_W-1:0] frc;
  } step_row_t;

  typedef struct packed {
    logic [IDX_W-1:0]        thr;
    logic signed [LVL_W-1:0] lvl;
    logic signed [FRC_W-1:0] frc;
  } force_sample_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [CRV_W-1:0]        cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [IDX_W-1:0]        thruster_index_i = '0;
  logic signed [CMD_W-1:0] command_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [IDX_W-1:0]        thruster_out_index_o;
  logic signed [LVL_W-1:0] actuator_level_o;
  logic signed [FRC_W-1:0] force_res_o;

  logic [LIM_W-1:0]        lim_q;
  logic [LIM_W-1:0]        dz_q;
  logic [LAG_W-1:0]        alpha_q;
  logic [DLY_W-1:0]        dly_q;
  logic [CRV_W-1:0]        crv_pos_q;
  logic [CRV_W-1:0]        crv_neg_q;
  logic signed [CMD_W-1:0] ring_mem [THR_COUNT][RING_DEPTH];
  logic [3:0]              slot_q [THR_COUNT];
  logic signed [LVL_W-1:0] level_q [THR_COUNT];

  force_sample_t pending_forces [$];
  step_row_t     script [$];
  int            mismatch_count = 0;
  int            quiet_cycles = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  bit            hold_request = 1'b0;

  thruster_actuator_model_unit #(
    .THRUSTERS  (THR_COUNT),
    .DELAY_DEPTH(RING_DEPTH)
  ) DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .thruster_index_i    (thruster_index_i),
    .command_i           (command_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .thruster_out_index_o(thruster_out_index_o),
    .actuator_level_o    (actuator_level_o),
    .force_res_o         (force_res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void apply_setting(input logic [CFG_IDX_W-1:0] r, input logic [CRV_W-1:0] v);
    case (r)
      REG_MAX_INPUT:       lim_q = v[LIM_W-1:0];
      REG_DEAD_ZONE:       dz_q = v[LIM_W-1:0];
      REG_LAG_COEFFICIENT: alpha_q = v[LAG_W-1:0];
      REG_DELAY_STEPS:     dly_q = v[DLY_W-1:0];
      REG_CURVE_POSITIVE:  crv_pos_q = v;
      REG_CURVE_NEGATIVE:  crv_neg_q = v;
      default: ;
    endcase
  endfunction

  function automatic logic signed [FRC_W-1:0] curve_force_of(input logic signed [LVL_W-1:0] lvl);
    logic [CRV_W-1:0]    cv;
    logic signed [127:0] a, b, c, m, acc;
    cv = (lvl < 0) ? crv_neg_q : crv_pos_q;
    a = $signed(cv[20:0]);
    b = $signed(cv[41:21]);
    c = $signed(cv[62:42]);
    m = lvl;
    if (m < 0) m = -m;
    acc = a * m * m + b * m * 128'sd65536 + (c <<< 24) + (128'sd1 <<< 23);
    acc = acc >>> 24;
    if (acc > 128'sd2147483647) return 32'sh7FFFFFFF;
    if (acc < -128'sd2147483648) return 32'sh80000000;
    return 32'(acc);
  endfunction

  function automatic void advance_thruster(input logic [IDX_W-1:0] thr,
                                           input logic [CMD_W-1:0] cmd,
                                           output logic signed [LVL_W-1:0] lvl,
                                           output logic signed [FRC_W-1:0] frc);
    longint     lim, dz, c, u, al, acc;
    int         taps;
    logic [3:0] wr, rd;
    lim = longint'(lim_q);
    dz = longint'(dz_q);
    c = longint'($signed(cmd));
    if (c > lim) c = lim;
    if (c < -lim) c = -lim;
    if ((c < 0 ? -c : c) < dz) c = 0;
    taps = (dly_q == 0) ? 1 : (dly_q > RING_DEPTH) ? RING_DEPTH : int'(dly_q);
    wr = slot_q[thr];
    ring_mem[thr][wr] = 16'(c);
    rd = wr - 4'(taps - 1);
    u = longint'(ring_mem[thr][rd]);
    slot_q[thr] = wr + 4'd1;
    al = longint'(alpha_q);
    acc = al * longint'(level_q[thr]) + (65536 - al) * u * 256 + 32768;
    acc = acc >>> 16;
    if (acc > lim * 256) acc = lim * 256;
    if (acc < -lim * 256) acc = -lim * 256;
    level_q[thr] = 24'(acc);
    lvl = 24'(acc);
    frc = curve_force_of(24'(acc));
  endfunction

  function automatic logic [CRV_W-1:0] curve_word(input logic [20:0] a, b, c);
    return {c, b, a};
  endfunction

  function automatic logic [20:0] rand_coef();
    if ($urandom_range(0, 3) == 0) return 21'($urandom());
    return 21'($urandom_range(0, 2047)) - 21'd1024;
  endfunction

  function automatic logic [CRV_W-1:0] spread(input logic [CRV_W-1:0] val, input int w);
    logic [63:0]      r;
    logic [CRV_W-1:0] keep;
    r = {$urandom(), $urandom()};
    keep = (63'd1 << w) - 63'd1;
    return (r[CRV_W-1:0] & ~keep) | (val & keep);
  endfunction

  function automatic step_row_t cfg_row(input logic [CFG_IDX_W-1:0] r, input logic [CRV_W-1:0] v);
    return '{ROW_CFG, r, v, 1'b0, '0, '0};
  endfunction

  function automatic step_row_t cmd_row(input logic [IDX_W-1:0] thr, input logic [CMD_W-1:0] cmd);
    return '{ROW_CMD, thr, {47'd0, cmd}, 1'b0, '0, '0};
  endfunction

  function automatic step_row_t known_row(input logic [IDX_W-1:0] thr, input logic [CMD_W-1:0] cmd,
                                          input logic signed [LVL_W-1:0] lvl,
                                          input logic signed [FRC_W-1:0] frc);
    return '{ROW_CMD, thr, {47'd0, cmd}, 1'b1, lvl, frc};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input logic [CRV_W-1:0] v);
    apply_setting(r, v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_forces.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_command(input logic [IDX_W-1:0] thr, input logic [CMD_W-1:0] cmd,
                              input logic typed, input logic signed [LVL_W-1:0] want_lvl,
                              input logic signed [FRC_W-1:0] want_frc);
    force_sample_t           want;
    logic signed [LVL_W-1:0] lvl;
    logic signed [FRC_W-1:0] frc;
    advance_thruster(thr, cmd, lvl, frc);
    want = '{thr, typed ? want_lvl : lvl, typed ? want_frc : frc};
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    thruster_index_i <= thr;
    command_i <= cmd;
    do @(posedge clk_i); while (in_stall_o);
    pending_forces.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic shuffle_settings();
    logic [LIM_W-1:0] v15;
    logic [LIM_W-1:0] dz;
    logic [LAG_W-1:0] v16;
    logic [DLY_W-1:0] v5;
    int               pick;
    pick = $urandom_range(0, 9);
    v15 = (pick == 0) ? 15'd0 : (pick < 3) ? 15'h7FFF :
          (pick < 6) ? 15'($urandom()) : 15'($urandom_range(0, 2000));
    write_reg(REG_MAX_INPUT, spread({48'd0, v15}, LIM_W));
    pick = $urandom_range(0, 9);
    dz = (pick < 4) ? 15'd0 : (pick == 4) ? 15'h7FFF :
         (pick < 8) ? 15'($urandom_range(0, 300)) : 15'($urandom());
    write_reg(REG_DEAD_ZONE, spread({48'd0, dz}, LIM_W));
    pick = $urandom_range(0, 5);
    v16 = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom());
    write_reg(REG_LAG_COEFFICIENT, spread({47'd0, v16}, LAG_W));
    v5 = ($urandom_range(0, 9) < 3) ? 5'($urandom()) : 5'($urandom_range(1, 16));
    write_reg(REG_DELAY_STEPS, spread({58'd0, v5}, DLY_W));
    write_reg(REG_CURVE_POSITIVE, curve_word(rand_coef(), rand_coef(), rand_coef()));
    write_reg(REG_CURVE_NEGATIVE, curve_word(rand_coef(), rand_coef(), rand_coef()));
  endtask

  task automatic run_burst(input int count);
    int               left;
    int               span;
    int               reach;
    logic [IDX_W-1:0] thr;
    logic [CMD_W-1:0] cmd;
    left = count;
    while (left > 0) begin
      thr = 3'($urandom_range(0, THR_COUNT - 1));
      span = $urandom_range(1, 6);
      while (span > 0 && left > 0) begin
        case ($urandom_range(0, 9))
          0: cmd = 16'h8000;
          1: cmd = 16'h7FFF;
          2: cmd = 16'h0000;
          3, 4, 5: begin
            reach = (int'(lim_q) + 50 > 32767) ? 32767 : int'(lim_q) + 50;
            cmd = 16'($urandom_range(0, 2 * reach) - reach);
          end
          default: cmd = 16'($urandom());
        endcase
        send_command(thr, cmd, 1'b0, '0, '0);
        span--;
        left--;
      end
    end
  endtask

  task automatic flag_error(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic check_transfer();
    force_sample_t want;
    if (pending_forces.size() == 0) begin
      flag_error("unexpected transfer, force", 0, longint'(force_res_o));
    end else begin
      want = pending_forces.pop_front();
      if (thruster_out_index_o !== want.thr)
        flag_error("thruster index", longint'(want.thr), longint'(thruster_out_index_o));
      if (actuator_level_o !== want.lvl)
        flag_error("actuator level", longint'(want.lvl), longint'(actuator_level_o));
      if (force_res_o !== want.frc)
        flag_error("force", longint'(want.frc), longint'(force_res_o));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_transfer();
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin
    lim_q = 15'h7FFF;
    dz_q = '0;
    alpha_q = '0;
    dly_q = 5'd1;
    crv_pos_q = '0;
    crv_neg_q = '0;
    foreach (ring_mem[t, k]) ring_mem[t][k] = '0;
    foreach (slot_q[t]) begin
      slot_q[t] = '0;
      level_q[t] = '0;
    end

    script.push_back(known_row(3'd0, 16'h0000, 24'sd0, 32'sd0));
    script.push_back(known_row(3'd0, 16'h7FFF, 24'sd8388352, 32'sd0));
    script.push_back(known_row(3'd1, 16'h8000, -24'sd8388352, 32'sd0));
    script.push_back(known_row(3'd7, 16'hFFFF, -24'sd256, 32'sd0));
    script.push_back(known_row(3'd7, 16'h0001, 24'sd256, 32'sd0));
    script.push_back(cfg_row(REG_MAX_INPUT, 63'd100));
    script.push_back(known_row(3'd2, 16'h7FFF, 24'sd25600, 32'sd0));
    script.push_back(known_row(3'd2, 16'h8000, -24'sd25600, 32'sd0));
    script.push_back(cfg_row(REG_MAX_INPUT, 63'h7FFF_FFFF_FFFF_8000));
    script.push_back(known_row(3'd3, 16'd12345, 24'sd0, 32'sd0));
    script.push_back(cfg_row(REG_MAX_INPUT, 63'd32767));
    script.push_back(cfg_row(REG_DEAD_ZONE, 63'd40));
    script.push_back(known_row(3'd3, 16'd39, 24'sd0, 32'sd0));
    script.push_back(known_row(3'd3, -16'sd40, -24'sd10240, 32'sd0));
    script.push_back(cfg_row(REG_MAX_INPUT, 63'd1000));
    script.push_back(cfg_row(REG_DEAD_ZONE, 63'd32767));
    script.push_back(known_row(3'd4, 16'h7FFF, 24'sd0, 32'sd0));
    script.push_back(known_row(3'd4, 16'h8000, 24'sd0, 32'sd0));
    script.push_back(cfg_row(REG_DEAD_ZONE, 63'd0));
    script.push_back(cfg_row(REG_DELAY_STEPS, 63'd0));
    script.push_back(known_row(3'd5, 16'd500, 24'sd128000, 32'sd0));
    script.push_back(cfg_row(REG_MAX_INPUT, 63'd32767));
    script.push_back(cfg_row(REG_DELAY_STEPS, 63'd31));
    script.push_back(cmd_row(3'd6, 16'd1000));
    script.push_back(cmd_row(3'd6, -16'sd2000));
    script.push_back(cmd_row(3'd6, 16'd3000));
    script.push_back(cfg_row(REG_DELAY_STEPS, 63'd3));
    script.push_back(cfg_row(REG_LAG_COEFFICIENT, 63'd65535));
    script.push_back(cfg_row(REG_CURVE_POSITIVE, curve_word(21'd300, -21'sd1200, 21'd5000)));
    script.push_back(cfg_row(REG_CURVE_NEGATIVE, curve_word(-21'sd77, 21'd900, -21'sd4000)));
    script.push_back(cmd_row(3'd0, 16'd20000));
    script.push_back(cmd_row(3'd0, -16'sd15000));
    script.push_back(cmd_row(3'd0, 16'd7));
    script.push_back(cmd_row(3'd0, 16'h8000));
    script.push_back(cfg_row(REG_LAG_COEFFICIENT, 63'd0));
    script.push_back(cfg_row(REG_DELAY_STEPS, 63'd1));
    script.push_back(cfg_row(REG_CURVE_POSITIVE,
                             curve_word(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF)));
    script.push_back(cfg_row(REG_CURVE_NEGATIVE,
                             curve_word(21'h100000, 21'h100000, 21'h100000)));
    script.push_back(known_row(3'd1, 16'h7FFF, 24'sd8388352, 32'sh7FFFFFFF));
    script.push_back(known_row(3'd1, 16'h8000, -24'sd8388352, 32'sh80000000));
    script.push_back(known_row(3'd2, 16'h0000, 24'sd0, 32'sd1048575));
    script.push_back(cfg_row(REG_LAG_COEFFICIENT, 63'd32768));
    script.push_back(cfg_row(REG_DELAY_STEPS, 63'd2));
    script.push_back(cfg_row(REG_SPARE, 63'h5A5A_5A5A_5A5A_5A5A));
    script.push_back(cmd_row(3'd3, 16'd12000));
    script.push_back(cmd_row(3'd3, -16'sd9000));

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        quiesce();
        write_reg(script[i].sel, script[i].data);
      end else begin
        send_command(script[i].sel, script[i].data[CMD_W-1:0], script[i].typed,
                     script[i].lvl, script[i].frc);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 33 : (mode == 1) ? 55 : 0;
      recv_stall_pct = (mode == 0) ? 55 : (mode == 1) ? 33 : 0;
      for (int ph = 0; ph < 6; ph++) begin
        quiesce();
        shuffle_settings();
        if (mode == 2 && ph == 1) hold_request = 1'b1;
        run_burst($urandom_range(55, 85));
      end
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_forces.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tam_pkg.sv
rtl/core/tam_mac.sv
rtl/core/tam_store.sv
rtl/core/thruster_actuator_model_unit.sv
dv/tb_top.sv
